// ----- src/bils_pkg.sv -----
// ----------------------------------------------------------------------------
// bils_pkg
// Shared types, opcodes and the per-pulse pin pattern for the bus injection
// load sequencer.
// ----------------------------------------------------------------------------
package bils_pkg;

   // command codes; code 3 is unused and produces no pulses
   typedef enum logic [1:0] {
      MODE_WARM_RESET = 2'd0,
      MODE_LOAD_PTR   = 2'd1,
      MODE_STORE_INC  = 2'd2
   } mode_type;

   localparam int unsigned MODE_WIDTH      = 2;
   localparam int unsigned VALUE_WIDTH     = 16;
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned PULSE_CNT_WIDTH = 4;

   // the one command code with no pulse run
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

   // injected opcodes
   localparam logic [BYTE_WIDTH-1:0] OP_LOAD_PTR = 8'h21;
   localparam logic [BYTE_WIDTH-1:0] OP_STORE    = 8'h36;
   localparam logic [BYTE_WIDTH-1:0] OP_INC_PTR  = 8'h23;

   // warm reset holds the reset line this many pulses
   localparam logic [PULSE_CNT_WIDTH-1:0] RESET_PULSES = 4'd6;

   // index of the final pulse of each command
   localparam logic [PULSE_CNT_WIDTH-1:0] LAST_WARM_RESET = 4'd7;
   localparam logic [PULSE_CNT_WIDTH-1:0] LAST_LOAD_PTR   = 4'd9;
   localparam logic [PULSE_CNT_WIDTH-1:0] LAST_STORE_INC  = 4'd15;

   // pin pattern for one cpu clock pulse
   typedef struct packed {
      logic                  reset_n;
      logic                  ram_enable;
      logic                  bus_drive;
      logic [BYTE_WIDTH-1:0] bus_value;
      logic                  last_pulse;
   } pulse_type;

   // true when the given pulse index is the final one of the command
   function automatic logic is_last_pulse(input logic [MODE_WIDTH-1:0] mode,
                                          input logic [PULSE_CNT_WIDTH-1:0] cnt);
      logic last;
      last = 1'b0;
      case (mode)
         MODE_WARM_RESET: last = (cnt == LAST_WARM_RESET);
         MODE_LOAD_PTR:   last = (cnt == LAST_LOAD_PTR);
         MODE_STORE_INC:  last = (cnt == LAST_STORE_INC);
         default:         last = 1'b1;
      endcase
      return last;
   endfunction

   // pin pattern of pulse cnt of a command
   function automatic pulse_type pulse_pattern(input logic [MODE_WIDTH-1:0]      mode,
                                               input logic [PULSE_CNT_WIDTH-1:0] cnt,
                                               input logic [VALUE_WIDTH-1:0]     value);
      pulse_type p;
      p.reset_n    = 1'b1;
      p.ram_enable = 1'b1;
      p.bus_drive  = 1'b0;
      p.bus_value  = '0;
      p.last_pulse = is_last_pulse(mode, cnt);
      case (mode)
         MODE_WARM_RESET: begin
            p.reset_n = (cnt >= RESET_PULSES);
         end
         MODE_LOAD_PTR: begin
            case (cnt)
               4'd0: ;
               4'd1, 4'd2: begin
                  p.ram_enable = 1'b0;
                  p.bus_drive  = 1'b1;
                  p.bus_value  = OP_LOAD_PTR;
               end
               4'd3, 4'd4: begin
                  p.ram_enable = 1'b0;
               end
               4'd5, 4'd6, 4'd7: begin
                  p.ram_enable = 1'b0;
                  p.bus_drive  = 1'b1;
                  p.bus_value  = value[BYTE_WIDTH-1:0];
               end
               default: begin
                  p.ram_enable = 1'b0;
                  p.bus_drive  = 1'b1;
                  p.bus_value  = value[VALUE_WIDTH-1:BYTE_WIDTH];
               end
            endcase
         end
         MODE_STORE_INC: begin
            case (cnt)
               4'd1, 4'd2: begin
                  p.ram_enable = 1'b0;
                  p.bus_drive  = 1'b1;
                  p.bus_value  = OP_STORE;
               end
               4'd3, 4'd4: begin
                  p.ram_enable = 1'b0;
               end
               4'd5, 4'd6: begin
                  p.ram_enable = 1'b0;
                  p.bus_drive  = 1'b1;
                  p.bus_value  = value[BYTE_WIDTH-1:0];
               end
               4'd11, 4'd12: begin
                  p.ram_enable = 1'b0;
                  p.bus_drive  = 1'b1;
                  p.bus_value  = OP_INC_PTR;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return p;
   endfunction

endpackage

// ----- src/bus_injection_load_sequencer.sv -----
// ----------------------------------------------------------------------------
// bus_injection_load_sequencer
// Turns one command into a run of cpu clock pulses, each carrying the reset,
// ram enable and data bus pattern that injects instructions onto the bus.
// ----------------------------------------------------------------------------
//
//   channel   ports                                  handshake
//   -------   -------------------------------------  -----------------------
//   command   req_mode, req_load_value               start high, busy low
//   pulse     rsp_reset_n, rsp_ram_enable,           rsp_strobe, one cycle,
//             rsp_bus_drive, rsp_bus_value,          no back pressure
//             rsp_last_pulse
//
// A warm reset gives 8 pulses, a pointer load 10 and a byte store 16, one per
// cycle; the pulse counter sets the rate. Pulses reach the ports through the
// command register and then the result register. busy drops during the cycle
// that computes the final pulse, so the next command follows with no gap. Mode
// 3 is taken and yields no pulses. reset clears the sequencer to idle.
module bus_injection_load_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [bils_pkg::MODE_WIDTH-1:0]       req_mode,
   input  logic [bils_pkg::VALUE_WIDTH-1:0]      req_load_value,
   output logic                                  rsp_strobe,
   output logic                                  rsp_reset_n,
   output logic                                  rsp_ram_enable,
   output logic                                  rsp_bus_drive,
   output logic [bils_pkg::BYTE_WIDTH-1:0]       rsp_bus_value,
   output logic                                  rsp_last_pulse
);

   // command register
   logic                                 active_ff;
   logic                                 active_in;
   logic [bils_pkg::MODE_WIDTH-1:0]      mode_ff;
   logic [bils_pkg::MODE_WIDTH-1:0]      mode_in;
   logic [bils_pkg::VALUE_WIDTH-1:0]     value_ff;
   logic [bils_pkg::VALUE_WIDTH-1:0]     value_in;
   logic [bils_pkg::PULSE_CNT_WIDTH-1:0] cnt_ff;
   logic [bils_pkg::PULSE_CNT_WIDTH-1:0] cnt_in;

   // result register
   logic                                 strobe_ff;
   bils_pkg::pulse_type                  pulse_ff;
   bils_pkg::pulse_type                  pulse_in;

   logic                                 final_pulse;
   logic                                 accept;

   // pulse pattern for the current count
   assign pulse_in    = bils_pkg::pulse_pattern(mode_ff, cnt_ff, value_ff);
   assign final_pulse = bils_pkg::is_last_pulse(mode_ff, cnt_ff);
   assign busy        = active_ff && !final_pulse;
   assign accept      = start && !busy;

   // next command state
   always_comb begin
      active_in = active_ff;
      mode_in   = mode_ff;
      value_in  = value_ff;
      cnt_in    = cnt_ff;
      if (active_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (final_pulse) begin
            active_in = 1'b0;
         end
      end
      if (accept) begin
         active_in = (req_mode != bils_pkg::MODE_UNUSED);
         mode_in   = req_mode;
         value_in  = req_load_value;
         cnt_in    = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= active_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      if (active_ff) begin
         pulse_ff <= pulse_in;
      end
   end

   // result ports
   assign rsp_strobe     = strobe_ff;
   assign rsp_reset_n    = pulse_ff.reset_n;
   assign rsp_ram_enable = pulse_ff.ram_enable;
   assign rsp_bus_drive  = pulse_ff.bus_drive;
   assign rsp_bus_value  = pulse_ff.bus_value;
   assign rsp_last_pulse = pulse_ff.last_pulse;

`ifndef SYNTHESIS
   // an idle sequencer always takes a command
   assert property (@(posedge clock) disable iff (reset) !active_ff |-> !busy)
      else $error("busy while idle");

   // a taken command with a real mode starts at pulse zero
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode != bils_pkg::MODE_UNUSED) |=> (active_ff && cnt_ff == '0))
      else $error("command not started at pulse zero");

   // an undriven bus reads as zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_bus_drive) |-> (rsp_bus_value == '0))
      else $error("bus value without drive");

   // reset pulses never drive the bus and keep ram enabled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_reset_n) |-> (rsp_ram_enable && !rsp_bus_drive))
      else $error("bus driven during cpu reset");
`endif

endmodule

// ----- dv/bus_injection_load_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_injection_load_sequencer_tb
// Drives warm reset, pointer load and byte store commands into the sequencer,
// plus the unused command code. Each accepted command is expanded into its
// expected run of pin patterns. Every strobed pulse is checked field by field
// against the oldest expected pulse. Directed corner cases come first, then
// random bursts of commands with random gaps and drain pauses.
// ----------------------------------------------------------------------------
module bus_injection_load_sequencer_tb;

   typedef logic [bils_pkg::MODE_WIDTH-1:0]  mode_bits_type;
   typedef logic [bils_pkg::VALUE_WIDTH-1:0] value_type;
   typedef logic [bils_pkg::BYTE_WIDTH-1:0]  byte_type;

   localparam int STALL_LIMIT   = 500;
   localparam int SETTLE_CYCLES = 24;

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          start          = 1'b0;
   mode_bits_type req_mode       = '0;
   value_type     req_load_value = '0;
   logic          busy;
   logic          rsp_strobe;
   logic          rsp_reset_n;
   logic          rsp_ram_enable;
   logic          rsp_bus_drive;
   byte_type      rsp_bus_value;
   logic          rsp_last_pulse;

   // pin patterns still owed by the block, oldest first
   bils_pkg::pulse_type pending_pulses[$];
   int                  error_count  = 0;
   int                  quiet_cycles = 0;

   bus_injection_load_sequencer uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_load_value (req_load_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_reset_n    (rsp_reset_n),
      .rsp_ram_enable (rsp_ram_enable),
      .rsp_bus_drive  (rsp_bus_drive),
      .rsp_bus_value  (rsp_bus_value),
      .rsp_last_pulse (rsp_last_pulse)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // append count identical pulses to the expected run
   function automatic void queue_pulses(input int count, input logic rst, input logic ram,
                                        input logic drv, input byte_type val);
      bils_pkg::pulse_type p;
      p.reset_n    = rst;
      p.ram_enable = ram;
      p.bus_drive  = drv;
      p.bus_value  = drv ? val : '0;
      p.last_pulse = 1'b0;
      repeat (count) pending_pulses.push_back(p);
   endfunction

   // expected pulse run of one command
   function automatic void predict_pulses(input mode_bits_type mode,
                                          input value_type     value);
      bils_pkg::pulse_type tail;
      case (mode)
         bils_pkg::MODE_WARM_RESET: begin
            queue_pulses(int'(bils_pkg::RESET_PULSES), 1'b0, 1'b1, 1'b0, '0);
            queue_pulses(2, 1'b1, 1'b1, 1'b0, '0);
         end
         bils_pkg::MODE_LOAD_PTR: begin
            queue_pulses(1, 1'b1, 1'b1, 1'b0, '0);
            queue_pulses(2, 1'b1, 1'b0, 1'b1, bils_pkg::OP_LOAD_PTR);
            queue_pulses(2, 1'b1, 1'b0, 1'b0, '0);
            queue_pulses(3, 1'b1, 1'b0, 1'b1, value[7:0]);
            queue_pulses(2, 1'b1, 1'b0, 1'b1, value[15:8]);
         end
         bils_pkg::MODE_STORE_INC: begin
            queue_pulses(1, 1'b1, 1'b1, 1'b0, '0);
            queue_pulses(2, 1'b1, 1'b0, 1'b1, bils_pkg::OP_STORE);
            queue_pulses(2, 1'b1, 1'b0, 1'b0, '0);
            queue_pulses(2, 1'b1, 1'b0, 1'b1, value[7:0]);
            queue_pulses(4, 1'b1, 1'b1, 1'b0, '0);
            queue_pulses(2, 1'b1, 1'b0, 1'b1, bils_pkg::OP_INC_PTR);
            queue_pulses(3, 1'b1, 1'b1, 1'b0, '0);
         end
         default: return;
      endcase
      // mark the final pulse of the run
      tail = pending_pulses.pop_back();
      tail.last_pulse = 1'b1;
      pending_pulses.push_back(tail);
   endfunction

   function automatic void check_field(input string name, input byte_type want,
                                       input byte_type got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // compare each strobed pulse with the oldest expected one
   always @(posedge clock) begin : check_pulses
      bils_pkg::pulse_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pulses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected pulse expected none actual %b %b %b %h %b", $time,
                     rsp_reset_n, rsp_ram_enable, rsp_bus_drive, rsp_bus_value,
                     rsp_last_pulse);
         end else begin
            want = pending_pulses.pop_front();
            check_field("reset_n", byte_type'(want.reset_n), byte_type'(rsp_reset_n));
            check_field("ram_enable", byte_type'(want.ram_enable),
                        byte_type'(rsp_ram_enable));
            check_field("bus_drive", byte_type'(want.bus_drive), byte_type'(rsp_bus_drive));
            check_field("bus_value", want.bus_value, rsp_bus_value);
            check_field("last_pulse", byte_type'(want.last_pulse),
                        byte_type'(rsp_last_pulse));
         end
      end
   end

   // watchdog: too long with no command transaction
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // one command transaction; start stays high for a following command
   task automatic send_command(input mode_bits_type mode,
                               input value_type     value);
      start          <= 1'b1;
      req_mode       <= mode;
      req_load_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pulses(mode, value);
   endtask

   // sender gap with junk on the command fields
   task automatic pause_sender(input int cycles);
      start          <= 1'b0;
      req_mode       <= mode_bits_type'($urandom);
      req_load_value <= value_type'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every expected pulse has arrived
   task automatic drain_pulses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_pulses.size() != 0) @(posedge clock);
   endtask

   task automatic test_warm_reset();
      send_command(bils_pkg::MODE_WARM_RESET, 16'h0000);
      send_command(bils_pkg::MODE_WARM_RESET, 16'hFFFF);
      drain_pulses();
   endtask

   task automatic test_load_pointer();
      value_type corners[6] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                                16'hA55A, 16'h1234};
      foreach (corners[i]) begin
         send_command(bils_pkg::MODE_LOAD_PTR, corners[i]);
         drain_pulses();
      end
   endtask

   // high byte of the value must not reach the bus
   task automatic test_store_byte();
      value_type corners[5] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                                16'h5AA5};
      foreach (corners[i]) begin
         send_command(bils_pkg::MODE_STORE_INC, corners[i]);
         drain_pulses();
      end
   endtask

   // unused code is taken and yields nothing
   task automatic test_unused_mode();
      send_command(bils_pkg::MODE_UNUSED, 16'hFFFF);
      pause_sender(3);
      send_command(bils_pkg::MODE_UNUSED, 16'h0000);
      send_command(bils_pkg::MODE_STORE_INC, 16'h3C3C);
      drain_pulses();
   endtask

   // commands with no gap between them
   task automatic test_back_to_back();
      send_command(bils_pkg::MODE_LOAD_PTR, 16'h8001);
      send_command(bils_pkg::MODE_STORE_INC, 16'h7E7E);
      send_command(bils_pkg::MODE_WARM_RESET, 16'h0000);
      send_command(bils_pkg::MODE_LOAD_PTR, 16'h0000);
      drain_pulses();
   endtask

   task automatic test_random_traffic(input int count);
      int            sent;
      int            burst;
      int            pick;
      mode_bits_type mode;
      value_type     value;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (sent < count) begin
               // mostly real commands, now and then the unused code
               pick = $urandom_range(0, 15);
               if (pick < 3) mode = bils_pkg::MODE_WARM_RESET;
               else if (pick < 9) mode = bils_pkg::MODE_LOAD_PTR;
               else if (pick < 15) mode = bils_pkg::MODE_STORE_INC;
               else mode = bils_pkg::MODE_UNUSED;
               case ($urandom_range(0, 7))
                  0: value = 16'h0000;
                  1: value = 16'hFFFF;
                  default: value = value_type'($urandom);
               endcase
               send_command(mode, value);
               sent++;
            end
         end
         // gap after the burst: drain, none, or a random pause
         case ($urandom_range(0, 3))
            0: drain_pulses();
            1: ;
            default: pause_sender($urandom_range(1, 20));
         endcase
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_warm_reset();
      test_load_pointer();
      test_store_byte();
      test_unused_mode();
      test_back_to_back();
      test_random_traffic(310);
      drain_pulses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pulses.size() != 0) begin
         error_count++;
         $display("%0t: pulses left over expected 0 actual %0d", $time,
                  pending_pulses.size());
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/bils_pkg.sv
src/bus_injection_load_sequencer.sv
dv/bus_injection_load_sequencer_tb.sv
